// ===== src/taf_pkg.sv =====
// ----------------------------------------------------------------------------
// taf_pkg: shared types and codes of the timeline ancestry filter
// Item layouts, command and result codes, and the entry type of the queue
// that sits between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package taf_pkg;

    localparam int TL_W  = 31;
    localparam int LSN_W = 64;
    localparam int ID_W  = 16;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NODE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ANSWER  = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [TL_W-1:0]  timeline;
        logic [TL_W-1:0]  other_timeline;
        logic [LSN_W-1:0] switch_lsn;
        logic [ID_W-1:0]  node_ident;
        logic             last_node;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic             is_ancestor;
        logic [LSN_W-1:0] found_lsn;
        logic [ID_W-1:0]  verdict_node;
        logic [TL_W-1:0]  reference_used;
        logic             last_verdict;
    } out_item_t;

    // queue entry: the item plus what the front learned about it
    typedef struct packed {
        in_item_t item;
        logic     same_tl;
    } queue_entry_t;

    typedef struct packed {
        logic [TL_W-1:0]  child;
        logic [TL_W-1:0]  parent;
        logic [LSN_W-1:0] lsn;
    } edge_t;

    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic [TL_W-1:0] tl;
    } node_t;

endpackage

`default_nettype wire

// ===== src/taf_ram.sv =====
// ----------------------------------------------------------------------------
// taf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module taf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/taf_front.sv =====
// ----------------------------------------------------------------------------
// taf_front: request intake and classification
// Accepts items, flags items whose two timelines are equal, and holds them in
// a two-entry queue for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module taf_front
    import taf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire in_item_t     req_data,
    output logic              q_valid,
    input  wire logic         q_pop,
    output queue_entry_t      q_entry
);

    queue_entry_t slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;
    queue_entry_t entry_in;

    // classify
    always_comb
    begin
        entry_in.item    = req_data;
        entry_in.same_tl = (req_data.timeline == req_data.other_timeline);
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_entry   = slot_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_pop && q_valid;

    // pointers and fill
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

// ===== src/taf_back.sv =====
// ----------------------------------------------------------------------------
// taf_back: command execution
// Keeps the edge table and node buffer, walks ancestry one table entry at a
// time with a read state and a check state, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module taf_back
    import taf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int MAX_NODES     = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire queue_entry_t    q_entry,
    input  wire logic [TL_W-1:0] pinned,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output out_item_t            rsp_data
);

    localparam int ECW = $clog2(HISTORY_DEPTH + 1);
    localparam int EIW = $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int NIW = $clog2(MAX_NODES > 1 ? MAX_NODES : 2);
    localparam logic [ECW-1:0] EDGE_FULL = ECW'(HISTORY_DEPTH);
    localparam logic [NCW-1:0] NODE_FULL = NCW'(MAX_NODES);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CHK = 8'b0000_0100,
        S_MAX_RD   = 8'b0000_1000,
        S_MAX_CHK  = 8'b0001_0000,
        S_NODE_RD  = 8'b0010_0000,
        S_NODE_CHK = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [ECW-1:0]  ecount_reg, ecount_next;
    logic [ECW-1:0]  idx_reg, idx_next;
    logic [NCW-1:0]  ncount_reg, ncount_next;
    logic [NCW-1:0]  nidx_reg, nidx_next;
    logic            batch_reg, batch_next;
    logic [TL_W-1:0] cand_reg, cand_next;
    logic [TL_W-1:0] cur_reg, cur_next;
    logic [TL_W-1:0] ref_reg, ref_next;
    out_item_t       pend_reg, pend_next;
    logic            rsp_valid_reg;
    out_item_t       rsp_data_reg;
    logic            load_rsp;

    logic            e_we, n_we;
    edge_t           e_wdata, e_rdata;
    node_t           n_wdata, n_rdata;
    in_item_t        it;
    logic            n_full;
    logic [NCW-1:0]  ncount_after;
    logic            is_last;

    taf_ram #(.WIDTH($bits(edge_t)), .DEPTH(HISTORY_DEPTH)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (ecount_reg[EIW-1:0]),
        .wdata (e_wdata),
        .raddr (idx_reg[EIW-1:0]),
        .rdata (e_rdata)
    );

    taf_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (ncount_reg[NIW-1:0]),
        .wdata (n_wdata),
        .raddr (nidx_reg[NIW-1:0]),
        .rdata (n_rdata)
    );

    assign it           = q_entry.item;
    assign e_wdata      = '{child: it.timeline, parent: it.other_timeline, lsn: it.switch_lsn};
    assign n_wdata      = '{ident: it.node_ident, tl: it.timeline};
    assign n_full       = (ncount_reg == NODE_FULL);
    assign ncount_after = ncount_reg + {{(NCW-1){1'b0}}, !n_full};
    assign is_last      = ((nidx_reg + NCW'(1)) == ncount_reg);
    assign load_rsp     = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_data     = rsp_data_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ecount_next = ecount_reg;
        idx_next    = idx_reg;
        ncount_next = ncount_reg;
        nidx_next   = nidx_reg;
        batch_next  = batch_reg;
        cand_next   = cand_reg;
        cur_next    = cur_reg;
        ref_next    = ref_reg;
        pend_next   = pend_reg;
        q_pop       = 1'b0;
        e_we        = 1'b0;
        n_we        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    batch_next = 1'b0;
                    pend_next  = '0;
                    case (it.cmd)
                        CMD_CLEAR:
                        begin
                            ecount_next = '0;
                        end
                        CMD_ADD:
                        begin
                            if (ecount_reg == EDGE_FULL)
                            begin
                                pend_next.result_kind = KIND_FULL;
                                state_next            = S_EMIT;
                            end
                            else
                            begin
                                e_we        = 1'b1;
                                ecount_next = ecount_reg + ECW'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (q_entry.same_tl)
                            begin
                                pend_next.result_kind = KIND_ANSWER;
                                pend_next.is_ancestor = 1'b1;
                                state_next            = S_EMIT;
                            end
                            else
                            begin
                                cand_next  = it.timeline;
                                cur_next   = it.other_timeline;
                                idx_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            n_we        = !n_full;
                            ncount_next = ncount_after;
                            if (it.last_node && (ncount_after != '0))
                            begin
                                nidx_next = '0;
                                if (pinned == '0)
                                begin
                                    ref_next   = '0;
                                    state_next = S_MAX_RD;
                                end
                                else
                                begin
                                    ref_next   = pinned;
                                    state_next = S_NODE_RD;
                                end
                            end
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg >= ecount_reg)
                begin
                    pend_next.is_ancestor = 1'b0;
                    pend_next.found_lsn   = '0;
                    state_next            = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (e_rdata.child == cur_reg)
                begin
                    if (e_rdata.parent == cand_reg)
                    begin
                        pend_next.is_ancestor = 1'b1;
                        pend_next.found_lsn   = batch_reg ? '0 : e_rdata.lsn;
                        state_next            = S_EMIT;
                    end
                    else if (e_rdata.parent == '0 || e_rdata.parent >= cur_reg)
                    begin
                        pend_next.is_ancestor = 1'b0;
                        pend_next.found_lsn   = '0;
                        state_next            = S_EMIT;
                    end
                    else
                    begin
                        cur_next   = e_rdata.parent;
                        idx_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + ECW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_MAX_RD:
            begin
                if (nidx_reg == ncount_reg)
                begin
                    nidx_next  = '0;
                    state_next = S_NODE_RD;
                end
                else
                begin
                    state_next = S_MAX_CHK;
                end
            end
            S_MAX_CHK:
            begin
                if (n_rdata.tl > ref_reg)
                begin
                    ref_next = n_rdata.tl;
                end
                nidx_next  = nidx_reg + NCW'(1);
                state_next = S_MAX_RD;
            end
            S_NODE_RD:
            begin
                state_next = S_NODE_CHK;
            end
            S_NODE_CHK:
            begin
                batch_next               = 1'b1;
                pend_next                = '0;
                pend_next.result_kind    = KIND_VERDICT;
                pend_next.verdict_node   = n_rdata.ident;
                pend_next.reference_used = ref_reg;
                pend_next.last_verdict   = is_last;
                // unreported node, no reference, or node on the reference itself
                if (ref_reg == '0 || n_rdata.tl == '0 || n_rdata.tl == ref_reg)
                begin
                    pend_next.is_ancestor = 1'b1;
                    state_next            = S_EMIT;
                end
                else
                begin
                    cand_next  = n_rdata.tl;
                    cur_next   = ref_reg;
                    idx_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_EMIT:
            begin
                if (load_rsp)
                begin
                    if (batch_reg && !is_last)
                    begin
                        nidx_next  = nidx_reg + NCW'(1);
                        state_next = S_NODE_RD;
                    end
                    else
                    begin
                        if (batch_reg)
                        begin
                            ncount_next = '0;
                        end
                        batch_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ecount_reg    <= '0;
            ncount_reg    <= '0;
            nidx_reg      <= '0;
            idx_reg       <= '0;
            batch_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ecount_reg <= ecount_next;
            ncount_reg <= ncount_next;
            nidx_reg   <= nidx_next;
            idx_reg    <= idx_next;
            batch_reg  <= batch_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        cur_reg   <= cur_next;
        ref_reg   <= ref_next;
        pend_reg  <= pend_next;
        if (load_rsp)
        begin
            rsp_data_reg <= pend_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/timeline_ancestry_filter.sv =====
// A query walks the edge table entry by entry, restarting the walk at each hop
// up the ancestry. A batch of nodes with no pinned reference first scans the
// node buffer for the highest timeline, then gives one verdict per node,
// walking the table where needed. The back handles one item at a time; a
// 2-entry queue keeps intake open meanwhile. Reset clears counts, queue
// pointers and the result valid flag; table contents are not cleared.
// ----------------------------------------------------------------------------
// timeline_ancestry_filter: timeline history and node ancestry filter
// Front queue, back sequencer with edge table and node buffer, config reg.
// ----------------------------------------------------------------------------
`default_nettype none

module timeline_ancestry_filter
    import taf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int MAX_NODES     = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire in_item_t        req_data,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output out_item_t            rsp_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [TL_W-1:0] cfg_data
);

    logic            q_valid;
    logic            q_pop;
    queue_entry_t    q_entry;
    logic [TL_W-1:0] pinned_reg;

    assign cfg_ready = 1'b1;

    // pinned reference register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pinned_reg <= '0;
        end
        else if (cfg_valid)
        begin
            pinned_reg <= cfg_data;
        end
    end

    taf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry)
    );

    taf_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_NODES     (MAX_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .pinned    (pinned_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // checks
    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.result_kind == KIND_ANSWER ||
                       rsp_data.result_kind == KIND_VERDICT ||
                       rsp_data.result_kind == KIND_FULL))
        else $error("unknown result kind");

    a_verdict_no_lsn: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.result_kind != KIND_ANSWER) |-> (rsp_data.found_lsn == '0))
        else $error("lsn on non-answer result");

    a_answer_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.result_kind == KIND_ANSWER) |->
            (rsp_data.verdict_node == '0 && rsp_data.reference_used == '0 &&
             !rsp_data.last_verdict && (rsp_data.is_ancestor || rsp_data.found_lsn == '0)))
        else $error("answer carries verdict fields");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
